// ===== design/csd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the contextual self-dissimilarity scorer.
// No dependencies; every other design file uses it by scoped names.
package csd_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_PATCH_RADIUS  = 3'd0;
  localparam logic [2:0] CFG_SEARCH_RADIUS = 3'd1;
  localparam logic [2:0] CFG_KNN           = 3'd2;
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd3;
  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd4;

  // Reset values of the registers
  localparam logic [2:0]  RST_PATCH_RADIUS  = 3'd3;
  localparam logic [3:0]  RST_SEARCH_RADIUS = 4'd5;
  localparam logic [3:0]  RST_KNN           = 4'd4;
  localparam logic [10:0] RST_IMAGE_WIDTH   = 11'd640;
  localparam logic [10:0] RST_IMAGE_HEIGHT  = 11'd480;

  // Position counters never exceed this
  localparam int COUNT_LIMIT = 1024;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [9:0]  center_col;
    logic [9:0]  center_row;
    logic [23:0] saliency;
    logic        frame_last;
  } result_t;

  // Clamped working configuration
  typedef struct packed {
    logic [3:0]  pr;
    logic [4:0]  sr;
    logic [4:0]  k;
    logic [10:0] weff;
    logic [10:0] heff;
  } cfg_eff_t;

  // Line store write from the front end
  typedef struct packed {
    logic       en;
    logic [5:0] ring_row;
    logic [9:0] col;
    logic [7:0] data;
  } line_wr_t;

  // One centre to score
  typedef struct packed {
    logic [9:0] cx;
    logic [9:0] cy;
    logic [5:0] crow;
    logic       last;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_SUM,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ===== design/csd_front.sv =====
`timescale 1ns / 1ps
// Front end: raster position tracking, line store writes, interior test.
// Depends on csd_pkg.
module csd_front #(
  parameter int RING_ROWS = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csd_pkg::pix_in_t   in_data,
  input  csd_pkg::cfg_eff_t  cfg,
  input  logic               can_take,
  output csd_pkg::line_wr_t  wr,
  output logic               push,
  output csd_pkg::job_t      job
);

  logic [9:0]  col_count;
  logic [9:0]  row_count;
  logic [5:0]  wrow;
  logic [9:0]  col_count_next;
  logic [9:0]  row_count_next;
  logic [5:0]  wrow_next;

  logic        accept;
  logic [10:0] c0, r0, r1, r2, cn, rn;
  logic [10:0] c1;
  logic [5:0]  w0, w1, w2, wn;
  logic [5:0]  border;
  logic [6:0]  border2;
  logic        interior;

  assign in_ready = can_take;
  assign accept   = in_valid && in_ready;
  assign border   = 6'(cfg.pr) + 6'(cfg.sr);
  assign border2  = {border, 1'b0};

  function automatic logic [5:0] ring_inc(input logic [5:0] w);
    logic [5:0] r;
    if (w == 6'(RING_ROWS - 1)) r = 6'd0;
    else r = w + 6'd1;
    return r;
  endfunction

  always_comb begin
    c0 = in_data.frame_start ? 11'd0 : {1'b0, col_count};
    r0 = in_data.frame_start ? 11'd0 : {1'b0, row_count};
    w0 = in_data.frame_start ? 6'd0 : wrow;
    if (c0 >= cfg.weff) begin
      c1 = 11'd0;
      r1 = r0 + 11'd1;
      w1 = ring_inc(w0);
    end else begin
      c1 = c0;
      r1 = r0;
      w1 = w0;
    end
    if (r1 >= cfg.heff) begin
      r2 = 11'd0;
      w2 = 6'd0;
    end else begin
      r2 = r1;
      w2 = w1;
    end
    cn = c1 + 11'd1;
    rn = r2;
    wn = w2;
    if (cn >= cfg.weff) begin
      cn = 11'd0;
      rn = r2 + 11'd1;
      wn = ring_inc(w2);
      if (rn >= cfg.heff) begin
        rn = 11'd0;
        wn = 6'd0;
      end
    end
    col_count_next = 10'(cn);
    row_count_next = 10'(rn);
    wrow_next      = wn;
  end

  assign interior = (r2 >= 11'(border2)) && (c1 >= 11'(border2));

  always_comb begin
    wr.en       = accept;
    wr.ring_row = w2;
    wr.col      = 10'(c1);
    wr.data     = in_data.pixel_value;
    push        = accept && interior;
    job.cx      = 10'(c1 - 11'(border));
    job.cy      = 10'(r2 - 11'(border));
    job.crow    = (w2 >= border) ? (w2 - border) : (w2 + 6'(RING_ROWS) - border);
    job.last    = (r2 + 11'd1 == cfg.heff) && (c1 + 11'd1 == cfg.weff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      wrow      <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      wrow      <= wrow_next;
    end
  end

endmodule

// ===== design/csd_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry queue of centre jobs between front and back end.
// Depends on csd_pkg.
module csd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csd_pkg::job_t  push_data,
  input  logic           pop,
  output csd_pkg::job_t  head,
  output logic           empty
);

  csd_pkg::job_t entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push && count != 2'd2) entries[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && count != 2'd2) wp <= ~wp;
      if (pop && !empty) rp <= ~rp;
      count <= count + 2'((push && count != 2'd2) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

// ===== design/csd_back.sv =====
`timescale 1ns / 1ps
// Back end: line store, per-pixel SSD pipeline, k-smallest list,
// sum and restoring divider, result register. Depends on csd_pkg.
module csd_back #(
  parameter int MAX_WIDTH         = 1024,
  parameter int MAX_PATCH_RADIUS  = 4,
  parameter int MAX_SEARCH_RADIUS = 8,
  parameter int MAX_KNN           = 8,
  parameter int RING_ROWS         = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  csd_pkg::cfg_eff_t  cfg,
  input  csd_pkg::line_wr_t  wr,
  input  csd_pkg::job_t      job_in,
  input  logic               job_avail,
  output logic               pop,
  output logic               busy,
  output logic               res_valid,
  input  logic               res_ready,
  output csd_pkg::result_t   res
);

  localparam int AW     = $clog2(RING_ROWS * MAX_WIDTH);
  localparam int UW     = $clog2(2 * MAX_PATCH_RADIUS + 1);
  localparam int DW     = $clog2(2 * MAX_SEARCH_RADIUS + 1);
  localparam int SIDE_M = 2 * MAX_PATCH_RADIUS + 1;
  localparam int SSD_W  = $clog2(SIDE_M * SIDE_M * 65025 + 1);
  localparam int NW     = $clog2(MAX_KNN + 1);
  localparam int IW     = (MAX_KNN > 1) ? $clog2(MAX_KNN) : 1;
  localparam int SUM_W  = SSD_W + NW;
  localparam int NUM_W  = SUM_W + 8;
  localparam int DEN_W  = $clog2(SIDE_M * SIDE_M * MAX_KNN + 1);
  localparam int CW     = $clog2(NUM_W + 1);
  localparam int RR     = RING_ROWS;

  csd_pkg::back_state_t state, state_next;

  logic [7:0] mem [RING_ROWS * MAX_WIDTH];
  logic [7:0] rd_a, rd_b;

  csd_pkg::job_t job;
  logic [DW-1:0] dy, dx;
  logic [UW-1:0] v, u;
  logic [UW-1:0] pr2;
  logic [DW-1:0] sr2, sr_d;
  logic          last_px, last_cand;

  logic [7:0]  ta, tc;
  logic [7:0]  ra, rc;
  logic [11:0] ca, cb;
  logic [AW-1:0] addr_a, addr_b, waddr;

  logic p1_valid, p1_last, p1_final;
  logic p2_valid, p2_last, p2_final;
  logic [15:0] sq;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic [SSD_W-1:0] acc, acc_sum;
  logic             ins_valid, ins_final;
  logic [SSD_W-1:0] ins_val;

  logic [SSD_W-1:0] best [MAX_KNN];
  logic [SSD_W-1:0] best_new [MAX_KNN];
  logic [MAX_KNN-1:0] le;
  logic [NW-1:0] n;
  logic [IW-1:0] sidx;
  logic [SUM_W-1:0] sum, sum_next;

  logic [8:0]  side_sq;
  logic [4:0]  side_s;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [NUM_W-1:0] quo;
  logic [CW-1:0]    dcnt;

  // Line store: one write port from the front end, two read ports
  assign waddr = AW'(wr.ring_row) * AW'(MAX_WIDTH) + AW'(wr.col);

  always_ff @(posedge clk) begin
    if (wr.en) mem[waddr] <= wr.data;
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Window addressing
  always_comb begin
    pr2       = UW'({cfg.pr, 1'b0});
    sr2       = DW'({cfg.sr, 1'b0});
    sr_d      = DW'(cfg.sr);
    last_px   = (u == pr2) && (v == pr2);
    last_cand = (dy == sr2) && (dx == sr2);
    ta = 8'(job.crow) + 8'(RR) + 8'(dy) + 8'(v) - 8'(cfg.sr) - 8'(cfg.pr);
    tc = 8'(job.crow) + 8'(RR) + 8'(v) - 8'(cfg.pr);
    if (ta >= 8'(2 * RR)) ra = ta - 8'(2 * RR);
    else if (ta >= 8'(RR)) ra = ta - 8'(RR);
    else ra = ta;
    if (tc >= 8'(2 * RR)) rc = tc - 8'(2 * RR);
    else if (tc >= 8'(RR)) rc = tc - 8'(RR);
    else rc = tc;
    ca = 12'(job.cx) + 12'(dx) + 12'(u) - 12'(cfg.sr) - 12'(cfg.pr);
    cb = 12'(job.cx) + 12'(u) - 12'(cfg.pr);
    addr_a = AW'(ra) * AW'(MAX_WIDTH) + AW'(ca);
    addr_b = AW'(rc) * AW'(MAX_WIDTH) + AW'(cb);
  end

  // Sorted insertion of a finished candidate SSD
  always_comb begin
    for (int i = 0; i < MAX_KNN; i++) begin
      le[i] = (NW'(i) < n) && (best[i] <= ins_val);
    end
    best_new[0] = le[0] ? best[0] : ins_val;
    for (int i = 1; i < MAX_KNN; i++) begin
      if (le[i]) best_new[i] = best[i];
      else if (le[i-1]) best_new[i] = ins_val;
      else best_new[i] = best[i-1];
    end
  end

  assign diff    = $signed({1'b0, rd_a}) - $signed({1'b0, rd_b});
  assign prod    = diff * diff;
  assign acc_sum = acc + SSD_W'(sq);
  assign sum_next = sum + SUM_W'(best[sidx]);
  assign rem_sh  = {rem, quo[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign side_s  = {cfg.pr, 1'b1};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      csd_pkg::B_IDLE:  if (job_avail) state_next = csd_pkg::B_RUN;
      csd_pkg::B_RUN:   if (last_px && last_cand) state_next = csd_pkg::B_DRAIN;
      csd_pkg::B_DRAIN: if (ins_valid && ins_final) state_next = csd_pkg::B_SUM;
      csd_pkg::B_SUM:   if (NW'(sidx) == n - NW'(1)) state_next = csd_pkg::B_DIV;
      csd_pkg::B_DIV:   if (dcnt == CW'(NUM_W - 1)) state_next = csd_pkg::B_OUT;
      csd_pkg::B_OUT:   if (!res_valid) state_next = csd_pkg::B_IDLE;
      default:          state_next = csd_pkg::B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop  = (state == csd_pkg::B_IDLE) && job_avail;
    busy = (state != csd_pkg::B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= csd_pkg::B_IDLE;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      ins_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      p1_valid  <= (state == csd_pkg::B_RUN);
      p2_valid  <= p1_valid;
      ins_valid <= p2_valid && p2_last;
      if (state == csd_pkg::B_OUT && !res_valid) res_valid <= 1'b1;
      else if (res_valid && res_ready) res_valid <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    side_sq  <= 9'(side_s) * 9'(side_s);
    den      <= DEN_W'(side_sq) * DEN_W'(cfg.k);
    p1_last  <= last_px;
    p1_final <= last_px && last_cand;
    p2_last  <= p1_last;
    p2_final <= p1_final;
    sq       <= 16'(prod);
    if (p2_valid) begin
      if (p2_last) begin
        ins_val   <= acc_sum;
        ins_final <= p2_final;
        acc       <= '0;
      end else begin
        acc <= acc_sum;
      end
    end
    if (ins_valid) begin
      for (int i = 0; i < MAX_KNN; i++) best[i] <= best_new[i];
      if (n < NW'(cfg.k)) n <= n + NW'(1);
    end
    case (state)
      csd_pkg::B_IDLE: begin
        if (job_avail) begin
          job  <= job_in;
          dy   <= '0;
          dx   <= '0;
          v    <= '0;
          u    <= '0;
          acc  <= '0;
          n    <= '0;
          sum  <= '0;
          sidx <= '0;
        end
      end
      csd_pkg::B_RUN: begin
        if (!last_px) begin
          if (u == pr2) begin
            u <= '0;
            v <= v + UW'(1);
          end else begin
            u <= u + UW'(1);
          end
        end else begin
          u <= '0;
          v <= '0;
          if (dx == sr2) begin
            dx <= '0;
            dy <= dy + DW'(1);
          end else if (dy == sr_d && dx + DW'(1) == sr_d) begin
            // skip the centre position itself
            dx <= sr_d + DW'(1);
          end else begin
            dx <= dx + DW'(1);
          end
        end
      end
      csd_pkg::B_SUM: begin
        sum  <= sum_next;
        sidx <= sidx + IW'(1);
        if (NW'(sidx) == n - NW'(1)) begin
          quo  <= {sum_next, 8'd0};
          rem  <= '0;
          dcnt <= '0;
        end
      end
      csd_pkg::B_DIV: begin
        rem  <= ge ? DEN_W'(rem_sh - {1'b0, den}) : DEN_W'(rem_sh);
        quo  <= {quo[NUM_W-2:0], ge};
        dcnt <= dcnt + CW'(1);
      end
      csd_pkg::B_OUT: begin
        if (!res_valid) begin
          res.center_col <= job.cx;
          res.center_row <= job.cy;
          res.saliency   <= (|quo[NUM_W-1:24]) ? 24'hFFFFFF : quo[23:0];
          res.frame_last <= job.last;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/contextual_self_dissimilarity.sv =====
`timescale 1ns / 1ps
// Per scored centre, after the transfer of its last window pixel, the back end compares
// the patch at each of the (2*sr+1)^2-1 candidate positions, one patch pixel pair a cycle,
// then sums the knn smallest SSDs and divides before out_valid rises.
// Throughput: one centre at a time; input stalls while a centre is queued or scored, or
// while its finished score waits behind a held one.
// Reset (rst, synchronous, active high) clears counters, queue and control; line store undefined.
module contextual_self_dissimilarity #(
  parameter int MAX_WIDTH         = 1024,
  parameter int MAX_PATCH_RADIUS  = 4,
  parameter int MAX_SEARCH_RADIUS = 8,
  parameter int MAX_KNN           = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  csd_pkg::pix_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output csd_pkg::result_t   out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int RING_ROWS = 2 * (MAX_PATCH_RADIUS + MAX_SEARCH_RADIUS) + 1;
  localparam int WMAX = (MAX_WIDTH < csd_pkg::COUNT_LIMIT) ? MAX_WIDTH
                                                           : csd_pkg::COUNT_LIMIT;

  // Programmed registers, raw as written
  logic [2:0]  patch_rad;
  logic [3:0]  search_radius;
  logic [3:0]  knn;
  logic [10:0] image_width;
  logic [10:0] image_height;

  csd_pkg::cfg_eff_t cfg;
  logic [5:0]  side_b;
  logic [10:0] cand;
  logic [4:0]  kc;

  csd_pkg::line_wr_t wr;
  csd_pkg::job_t     job_push, job_head;
  logic push, pop, q_empty, back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      patch_rad     <= csd_pkg::RST_PATCH_RADIUS;
      search_radius <= csd_pkg::RST_SEARCH_RADIUS;
      knn           <= csd_pkg::RST_KNN;
      image_width   <= csd_pkg::RST_IMAGE_WIDTH;
      image_height  <= csd_pkg::RST_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        csd_pkg::CFG_PATCH_RADIUS:  patch_rad     <= cfg_data[2:0];
        csd_pkg::CFG_SEARCH_RADIUS: search_radius <= cfg_data[3:0];
        csd_pkg::CFG_KNN:           knn           <= cfg_data[3:0];
        csd_pkg::CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
        csd_pkg::CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp registers to their working ranges; knn also to the candidate count
  always_comb begin
    if (patch_rad == 3'd0) cfg.pr = 4'd1;
    else if (32'(patch_rad) > MAX_PATCH_RADIUS) cfg.pr = 4'(MAX_PATCH_RADIUS);
    else cfg.pr = 4'(patch_rad);

    if (search_radius == 4'd0) cfg.sr = 5'd1;
    else if (32'(search_radius) > MAX_SEARCH_RADIUS) cfg.sr = 5'(MAX_SEARCH_RADIUS);
    else cfg.sr = 5'(search_radius);

    side_b = {cfg.sr, 1'b1};
    cand   = 11'(side_b) * 11'(side_b) - 11'd1;
    if (knn == 4'd0) kc = 5'd1;
    else if (32'(knn) > MAX_KNN) kc = 5'(MAX_KNN);
    else kc = 5'(knn);
    if (11'(kc) > cand) kc = 5'(cand);
    cfg.k = kc;

    if (image_width == 11'd0) cfg.weff = 11'd1;
    else if (32'(image_width) > WMAX) cfg.weff = 11'(WMAX);
    else cfg.weff = image_width;

    if (image_height == 11'd0) cfg.heff = 11'd1;
    else if (32'(image_height) > csd_pkg::COUNT_LIMIT) cfg.heff = 11'(csd_pkg::COUNT_LIMIT);
    else cfg.heff = image_height;
  end

  // Front end takes pixels only when no centre is queued or being scored, so
  // no store write can land on rows a running centre still reads.
  csd_front #(
    .RING_ROWS (RING_ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .can_take (q_empty && !back_busy),
    .wr       (wr),
    .push     (push),
    .job      (job_push)
  );

  csd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (job_push),
    .pop       (pop),
    .head      (job_head),
    .empty     (q_empty)
  );

  // Back end owns the result register: a finished score waits there while
  // the front end already takes further pixels.
  csd_back #(
    .MAX_WIDTH         (MAX_WIDTH),
    .MAX_PATCH_RADIUS  (MAX_PATCH_RADIUS),
    .MAX_SEARCH_RADIUS (MAX_SEARCH_RADIUS),
    .MAX_KNN           (MAX_KNN),
    .RING_ROWS         (RING_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .wr        (wr),
    .job_in    (job_head),
    .job_avail (!q_empty),
    .pop       (pop),
    .busy      (back_busy),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (out_data)
  );

endmodule
